// File: design/tmw_pkg.sv
// Package for the trimmed-mean load-cell weigher.
// Holds field widths, register indexes, reset values and limit constants.
// Depends on nothing; tmw_result_if and the top level use it.
package tmw_pkg;

  localparam int RAW_W = 24;
  localparam int WEIGHT_W = 32;
  localparam int TARE_W = 24;
  localparam int GAIN_W = 32;
  localparam int WCOUNT_W = 7;
  localparam int NET_W = 25;
  localparam int PROD_W = NET_W + GAIN_W;
  localparam int SCALE_SHIFT = 16;
  localparam int RMAG_W = PROD_W - SCALE_SHIFT;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int REG_SEL_W = 2;
  localparam int MIN_WINDOW = 3;

  localparam logic [REG_SEL_W-1:0] REG_WINDOW_COUNT = 2'd0;
  localparam logic [REG_SEL_W-1:0] REG_TARE = 2'd1;
  localparam logic [REG_SEL_W-1:0] REG_GAIN_Q24 = 2'd2;

  localparam logic [WCOUNT_W-1:0] WCOUNT_RST = 7'd40;
  localparam logic signed [TARE_W-1:0] TARE_RST = 24'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_RST = -32'sd1593835;

  localparam logic signed [RAW_W-1:0] RAW_MAX = 24'sh7FFFFF;
  localparam logic signed [RAW_W-1:0] RAW_MIN = 24'sh800000;
  localparam logic [RAW_W:0] RAW_POS_LIM = 25'h07FFFFF;
  localparam logic [RAW_W:0] RAW_NEG_LIM = 25'h0800000;

  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 32'sh7FFFFFFF;
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 32'sh80000000;
  localparam logic [RMAG_W-1:0] WEIGHT_POS_LIM = RMAG_W'(32'h7FFFFFFF);
  localparam logic [RMAG_W-1:0] WEIGHT_NEG_LIM = RMAG_W'(32'h80000000);

  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

endpackage

// File: design/tmw_sample_if.sv
// Input channel of the weigher: one raw ADC sample per beat.
// Valid/ready handshake; sample width follows SAMPLE_BITS.
// Depends on nothing.
interface tmw_sample_if #(
  parameter int SAMPLE_BITS = 24
);
  logic valid;
  logic ready;
  logic signed [SAMPLE_BITS-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink (input valid, input adc_sample, output ready);
endinterface

// File: design/tmw_result_if.sv
// Result channel of the weigher: trimmed mean and scaled weight per beat.
// Valid/ready handshake; widths come from tmw_pkg.
// Depends on tmw_pkg.
interface tmw_result_if;
  logic valid;
  logic ready;
  logic signed [tmw_pkg::RAW_W-1:0] trimmed_raw;
  logic signed [tmw_pkg::WEIGHT_W-1:0] weight_q8;
  logic weight_saturated;

  modport source (output valid, output trimmed_raw, output weight_q8,
                  output weight_saturated, input ready);
  modport sink (input valid, input trimmed_raw, input weight_q8,
                input weight_saturated, output ready);
endinterface

// File: design/tmw_serdiv.sv
// Bit-serial restoring divider for unsigned operands, one quotient bit a cycle.
// Done pulses when the quotient is valid.
// Depends on nothing.
module tmw_serdiv #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] quo_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    diff = shifted - {1'b0, den_r};
    fits = (shifted >= {1'b0, den_r});
    rem_nxt = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        quo_r <= num;
        rem_r <= '0;
        den_r <= den;
        cnt_r <= CNT_W'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo = quo_r;
endmodule

// File: design/tmw_sermul.sv
// Bit-serial shift-add multiplier for unsigned operands, one bit of a a cycle.
// Done pulses when the product is valid.
// Depends on nothing.
module tmw_sermul #(
  parameter int A_W = 25,
  parameter int B_W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [A_W-1:0]       a,
  input  logic [B_W-1:0]       b,
  output logic                 done,
  output logic [A_W+B_W-1:0]   prod
);
  localparam int CNT_W = $clog2(A_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [B_W-1:0]     b_r;
  logic [A_W+B_W-1:0] p_r;

  logic [B_W-1:0]     addend;
  logic [B_W:0]       psum;
  logic [A_W+B_W-1:0] p_nxt;

  always_comb begin
    addend = p_r[0] ? b_r : '0;
    psum = {1'b0, p_r[A_W+B_W-1:A_W]} + {1'b0, addend};
    p_nxt = {psum, p_r[A_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        p_r <= {{B_W{1'b0}}, a};
        b_r <= b;
        cnt_r <= CNT_W'(A_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        p_r <= p_nxt;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = p_r;
endmodule

// File: design/trimmed_mean_load_cell_weigher.sv
// Top level of the trimmed-mean load-cell weigher with its APB register file.
// Depends on tmw_pkg, tmw_sample_if, tmw_result_if, tmw_serdiv and tmw_sermul.
//
//   channel   direction  beat contents
//   in_bus    sink       adc_sample
//   out_bus   source     trimmed_raw, weight_q8, weight_saturated
//   APB       slave      window_count at 0x0, tare at 0x4, gain_q24 at 0x8
//
// A sample that does not close its window leaves the input ready for the next sample.
// A closing sample holds the input through the trim, the bit-serial divider
// (one bit per cycle), the serial multiplier, rounding and packing of the result.
// Reset is synchronous and clears window state and registers to their defaults.
// A waiting result does not block input; only a second finished window stalls.
module trimmed_mean_load_cell_weigher #(
  parameter int MAX_WINDOW = 64,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  tmw_sample_if.sink                   in_bus,
  tmw_result_if.source                 out_bus,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tmw_pkg::ADDR_W-1:0]   paddr,
  input  logic [tmw_pkg::DATA_W-1:0]   pwdata,
  output logic [tmw_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int CMP_W = (CNT_W > tmw_pkg::WCOUNT_W) ? CNT_W : tmw_pkg::WCOUNT_W;
  localparam int QX_W = (SUM_W > tmw_pkg::RAW_W + 1) ? SUM_W : tmw_pkg::RAW_W + 1;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_ABS, S_DIV, S_SAT, S_NET, S_MSTART, S_MUL, S_ROUND, S_PACK
  } state_t;

  state_t state_r;

  logic [tmw_pkg::WCOUNT_W-1:0]        wcount_r;
  logic signed [tmw_pkg::TARE_W-1:0]   tare_r;
  logic signed [tmw_pkg::GAIN_W-1:0]   gain_r;

  logic signed [SUM_W-1:0]       sum_r;
  logic signed [SAMPLE_BITS-1:0] min_r;
  logic signed [SAMPLE_BITS-1:0] max_r;
  logic [CNT_W-1:0]              seen_r;

  logic signed [SUM_W-1:0]             num_r;
  logic [CNT_W-1:0]                    den_r;
  logic                                qneg_r;
  logic signed [tmw_pkg::RAW_W-1:0]    trim_r;
  logic signed [tmw_pkg::NET_W-1:0]    net_r;
  logic                                pneg_r;
  logic [tmw_pkg::RMAG_W-1:0]          rmag_r;

  logic                                out_valid_r;
  logic signed [tmw_pkg::RAW_W-1:0]    out_trim_r;
  logic signed [tmw_pkg::WEIGHT_W-1:0] out_weight_r;
  logic                                out_sat_r;

  logic                                in_fire;
  logic                                cfg_wr;
  logic                                out_free;
  logic                                out_valid_nxt;
  logic [CMP_W-1:0]                    wc_ext;
  logic [CMP_W-1:0]                    n_eff;
  logic signed [SUM_W-1:0]             samp_ext;
  logic signed [SUM_W-1:0]             sum_nxt;
  logic signed [SAMPLE_BITS-1:0]       min_nxt;
  logic signed [SAMPLE_BITS-1:0]       max_nxt;
  logic [CNT_W-1:0]                    seen_nxt;
  logic                                closes;
  logic signed [SUM_W-1:0]             num_nxt;
  logic [SUM_W-1:0]                    num_mag;
  logic [QX_W-1:0]                     qx;
  logic signed [tmw_pkg::RAW_W-1:0]    trim_nxt;
  logic signed [tmw_pkg::NET_W-1:0]    net_nxt;
  logic [tmw_pkg::NET_W-1:0]           net_mag;
  logic [tmw_pkg::GAIN_W-1:0]          gain_mag;
  logic [tmw_pkg::PROD_W-1:0]          rnd_sum;
  logic signed [tmw_pkg::WEIGHT_W-1:0] weight_nxt;
  logic                                sat_nxt;

  logic                                div_start;
  logic                                div_done;
  logic [SUM_W-1:0]                    div_quo;
  logic                                mul_start;
  logic                                mul_done;
  logic [tmw_pkg::PROD_W-1:0]          mul_prod;

  assign in_bus.ready = (state_r == S_IDLE);
  assign in_fire = in_bus.valid && (state_r == S_IDLE);
  assign cfg_wr = psel && penable && pwrite;
  assign out_free = !out_valid_r || out_bus.ready;
  assign div_start = (state_r == S_ABS);
  assign mul_start = (state_r == S_MSTART);

  always_comb begin
    wc_ext = CMP_W'(wcount_r);
    if (wc_ext < CMP_W'(tmw_pkg::MIN_WINDOW)) begin
      n_eff = CMP_W'(tmw_pkg::MIN_WINDOW);
    end else if (wc_ext > CMP_W'(MAX_WINDOW)) begin
      n_eff = CMP_W'(MAX_WINDOW);
    end else begin
      n_eff = wc_ext;
    end

    samp_ext = {{(SUM_W-SAMPLE_BITS){in_bus.adc_sample[SAMPLE_BITS-1]}}, in_bus.adc_sample};
    sum_nxt = sum_r + samp_ext;
    min_nxt = (in_bus.adc_sample < min_r) ? in_bus.adc_sample : min_r;
    max_nxt = (in_bus.adc_sample > max_r) ? in_bus.adc_sample : max_r;
    seen_nxt = seen_r + 1'b1;
    closes = (CMP_W'(seen_nxt) >= n_eff);

    num_nxt = sum_r - ({{(SUM_W-SAMPLE_BITS){min_r[SAMPLE_BITS-1]}}, min_r}
                     + {{(SUM_W-SAMPLE_BITS){max_r[SAMPLE_BITS-1]}}, max_r});
    num_mag = num_r[SUM_W-1] ? (~num_r + 1'b1) : num_r;

    qx = QX_W'(div_quo);
    if (!qneg_r) begin
      trim_nxt = (qx > QX_W'(tmw_pkg::RAW_POS_LIM)) ? tmw_pkg::RAW_MAX
                                                     : qx[tmw_pkg::RAW_W-1:0];
    end else begin
      trim_nxt = (qx > QX_W'(tmw_pkg::RAW_NEG_LIM)) ? tmw_pkg::RAW_MIN
                                                     : (~qx[tmw_pkg::RAW_W-1:0] + 1'b1);
    end

    net_nxt = {trim_r[tmw_pkg::RAW_W-1], trim_r} - {tare_r[tmw_pkg::TARE_W-1], tare_r};
    net_mag = net_r[tmw_pkg::NET_W-1] ? (~net_r + 1'b1) : net_r;
    gain_mag = gain_r[tmw_pkg::GAIN_W-1] ? (~gain_r + 1'b1) : gain_r;

    rnd_sum = mul_prod + tmw_pkg::ROUND_HALF;

    if (pneg_r) begin
      sat_nxt = (rmag_r > tmw_pkg::WEIGHT_NEG_LIM);
      weight_nxt = sat_nxt ? tmw_pkg::WEIGHT_MIN
                           : (~rmag_r[tmw_pkg::WEIGHT_W-1:0] + 1'b1);
    end else begin
      sat_nxt = (rmag_r > tmw_pkg::WEIGHT_POS_LIM);
      weight_nxt = sat_nxt ? tmw_pkg::WEIGHT_MAX : rmag_r[tmw_pkg::WEIGHT_W-1:0];
    end

    out_valid_nxt = out_valid_r && !out_bus.ready;
    if ((state_r == S_PACK) && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wcount_r <= tmw_pkg::WCOUNT_RST;
      tare_r <= tmw_pkg::TARE_RST;
      gain_r <= tmw_pkg::GAIN_RST;
      sum_r <= '0;
      min_r <= SAMPLE_MAX;
      max_r <= SAMPLE_MIN;
      seen_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr[3:2])
          tmw_pkg::REG_WINDOW_COUNT: wcount_r <= pwdata[tmw_pkg::WCOUNT_W-1:0];
          tmw_pkg::REG_TARE:         tare_r <= pwdata[tmw_pkg::TARE_W-1:0];
          tmw_pkg::REG_GAIN_Q24:     gain_r <= pwdata[tmw_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end

      out_valid_r <= out_valid_nxt;

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            sum_r <= sum_nxt;
            min_r <= min_nxt;
            max_r <= max_nxt;
            seen_r <= seen_nxt;
            if (closes) begin
              state_r <= S_PREP;
            end
          end
        end
        S_PREP: begin
          num_r <= num_nxt;
          den_r <= seen_r - CNT_W'(2);
          state_r <= S_ABS;
        end
        S_ABS: begin
          qneg_r <= num_r[SUM_W-1];
          sum_r <= '0;
          min_r <= SAMPLE_MAX;
          max_r <= SAMPLE_MIN;
          seen_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          trim_r <= trim_nxt;
          state_r <= S_NET;
        end
        S_NET: begin
          net_r <= net_nxt;
          state_r <= S_MSTART;
        end
        S_MSTART: begin
          pneg_r <= net_r[tmw_pkg::NET_W-1] ^ gain_r[tmw_pkg::GAIN_W-1];
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          rmag_r <= rnd_sum[tmw_pkg::PROD_W-1:tmw_pkg::SCALE_SHIFT];
          state_r <= S_PACK;
        end
        S_PACK: begin
          if (out_free) begin
            out_trim_r <= trim_r;
            out_weight_r <= weight_nxt;
            out_sat_r <= sat_nxt;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  tmw_serdiv #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_mag),
    .den   (den_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  tmw_sermul #(
    .A_W(tmw_pkg::NET_W),
    .B_W(tmw_pkg::GAIN_W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (net_mag),
    .b     (gain_mag),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  always_comb begin
    unique case (paddr[3:2])
      tmw_pkg::REG_WINDOW_COUNT: prdata = tmw_pkg::DATA_W'(wcount_r);
      tmw_pkg::REG_TARE:
        prdata = {{(tmw_pkg::DATA_W-tmw_pkg::TARE_W){tare_r[tmw_pkg::TARE_W-1]}}, tare_r};
      tmw_pkg::REG_GAIN_Q24:     prdata = gain_r;
      default:                   prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  assign out_bus.valid = out_valid_r;
  assign out_bus.trimmed_raw = out_trim_r;
  assign out_bus.weight_q8 = out_weight_r;
  assign out_bus.weight_saturated = out_sat_r;
endmodule
